// ----- hdl/mmf_pkg.sv -----
// Shared constants, types and helpers for the masked median filter.
package mmf_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned WINDOW_SIZE_DEF = 3;
  localparam int unsigned MAX_WIDTH_DEF   = 1024;
  localparam int unsigned PIXEL_BITS_DEF  = 24;

  // Configuration port and register field widths.
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned WIDTH_W    = 11;
  localparam int unsigned HEIGHT_W   = 12;
  localparam int unsigned WEIGHT_W   = 4;

  localparam logic [WEIGHT_W-1:0] MAX_WEIGHT = 4'd9;

  // Register reset values.
  localparam logic [WIDTH_W-1:0]    WIDTH_RST   = 11'd640;
  localparam logic [HEIGHT_W-1:0]   HEIGHT_RST  = 12'd480;
  localparam logic [CFG_DATA_W-1:0] MASK_LO_RST = 64'h0000_0001_1111_1111;
  localparam logic [CFG_DATA_W-1:0] MASK_HI_RST = 64'h0;

  // Queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [QCNT_W-1:0] qcnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_MASK_LO = 2'd2,
    CFG_MASK_HI = 2'd3
  } cfg_idx_e;

  // Effective frame geometry and a restart pulse for the position counters.
  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic                restart;
  } geom_t;

  // Mask weights above the maximum saturate.
  function automatic logic [WEIGHT_W-1:0] sat_weight(input logic [WEIGHT_W-1:0] w);
    return (w > MAX_WEIGHT) ? MAX_WEIGHT : w;
  endfunction

endpackage

// ----- hdl/mmf_if.sv -----
// Stream interfaces for pixel beats in and filtered beats out.
interface mmf_in_if #(
  parameter int unsigned PIXEL_BITS = mmf_pkg::PIXEL_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [PIXEL_BITS-1:0] pixel;

  modport source (output valid, kind, pixel, input ready);
  modport sink (input valid, kind, pixel, output ready);
endinterface

interface mmf_out_if #(
  parameter int unsigned OUT_W = mmf_pkg::PIXEL_BITS_DEF + mmf_pkg::WEIGHT_W
);
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] filtered;
  logic                    window_empty;
  logic                    last_of_frame;

  modport source (output valid, filtered, window_empty, last_of_frame, input ready);
  modport sink (input valid, filtered, window_empty, last_of_frame, output ready);
endinterface

// ----- hdl/mmf_front.sv -----
// Front part: accepts pixel beats, keeps the line stores and the window, queues windows.
module mmf_front #(
  parameter int unsigned WINDOW_SIZE = mmf_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned MAX_WIDTH   = mmf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS  = mmf_pkg::PIXEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mmf_pkg::geom_t        geom_i,
  input  mmf_pkg::qcnt_t        q_cnt_i,
  mmf_in_if.sink                in_s,
  output logic                  push_o,
  output logic [WINDOW_SIZE*WINDOW_SIZE*(PIXEL_BITS+1):0] entry_o
);
  import mmf_pkg::*;

  localparam int unsigned HALF = WINDOW_SIZE / 2;
  localparam int unsigned TAPS = WINDOW_SIZE * WINDOW_SIZE;
  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW   = HEIGHT_W + 1;
  localparam int unsigned SW   = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned XW   = ((CW > HEIGHT_W) ? CW : HEIGHT_W) + 2;
  localparam int unsigned LW   = $clog2(HALF * MAX_WIDTH + HALF + 2);
  localparam int unsigned QW   = QCNT_W + 1;

  // Bank that holds window row dy, given the bank of the newest row.
  function automatic logic [SW-1:0] bank_of(input logic [SW-1:0] s, input int unsigned dy);
    logic [SW:0] t;
    t = (SW+1)'(s) + (SW+1)'(dy + 1);
    if (t >= (SW+1)'(WINDOW_SIZE)) t = t - (SW+1)'(WINDOW_SIZE);
    return t[SW-1:0];
  endfunction

  logic [CW-1:0]                in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0]                in_row_q, in_row_d;
  logic [HEIGHT_W-1:0]          out_row_q, out_row_d;
  logic [SW-1:0]                slot_q, slot_d;
  logic [LW-1:0]                lead_q, lead_d, lat;
  logic                         accept, emit, last, store;
  logic signed [PIXEL_BITS-1:0] pix_v;
  logic [TAPS-1:0]              ok;
  logic [XW-1:0]                w_x, h_x;
  logic [PIXEL_BITS-1:0]        rd_w [WINDOW_SIZE];

  logic                         s1_vld_q;
  logic                         s1_emit_q, s1_last_q;
  logic [PIXEL_BITS-1:0]        s1_pix_q;
  logic [SW-1:0]                s1_slot_q;
  logic [TAPS-1:0]              s1_ok_q;
  logic [PIXEL_BITS-1:0]        col [WINDOW_SIZE];
  logic [PIXEL_BITS-1:0]        win_q [WINDOW_SIZE][WINDOW_SIZE];
  logic [PIXEL_BITS-1:0]        win_d [WINDOW_SIZE][WINDOW_SIZE];

  assign w_x = XW'(geom_i.width);
  assign h_x = XW'(geom_i.height);
  assign lat = LW'(HALF) * LW'(geom_i.width) + LW'(HALF);

  // Take a beat only when the queue has room for it and the one in flight.
  assign in_s.ready = (QW'(q_cnt_i) + QW'(s1_vld_q)) < QW'(QUEUE_DEPTH);
  assign accept     = in_s.valid && in_s.ready;

  // Classify the beat: does it store a pixel, does it produce an output.
  assign emit  = (lead_q >= lat);
  assign last  = emit && (XW'(out_row_q) == h_x - 1'b1) && (XW'(out_col_q) == w_x - 1'b1);
  assign store = XW'(in_row_q) < h_x;
  assign pix_v = in_s.kind ? '0 : in_s.pixel;

  // Taps that fall inside the frame around the output position.
  always_comb begin
    for (int dy = 0; dy < WINDOW_SIZE; dy++) begin
      for (int dx = 0; dx < WINDOW_SIZE; dx++) begin
        ok[dy*WINDOW_SIZE+dx] = (XW'(out_row_q) + XW'(dy) >= XW'(HALF)) &&
                                (XW'(out_row_q) + XW'(dy) < h_x + XW'(HALF)) &&
                                (XW'(out_col_q) + XW'(dx) >= XW'(HALF)) &&
                                (XW'(out_col_q) + XW'(dx) < w_x + XW'(HALF));
      end
    end
  end

  // Position counters.
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    slot_d    = slot_q;
    lead_d    = lead_q;
    if (geom_i.restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      slot_d    = '0;
      lead_d    = '0;
    end else if (accept) begin
      if (!emit) begin
        lead_d = lead_q + 1'b1;
      end
      if (last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
        slot_d    = '0;
        lead_d    = '0;
      end else begin
        if (emit) begin
          if (XW'(out_col_q) == w_x - 1'b1) begin
            out_col_d = '0;
            out_row_d = out_row_q + 1'b1;
          end else begin
            out_col_d = out_col_q + 1'b1;
          end
        end
        if (XW'(in_col_q) == w_x - 1'b1) begin
          in_col_d = '0;
          in_row_d = in_row_q + 1'b1;
          slot_d   = (slot_q == SW'(WINDOW_SIZE - 1)) ? '0 : slot_q + 1'b1;
        end else begin
          in_col_d = in_col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      slot_q    <= '0;
      lead_q    <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      slot_q    <= slot_d;
      lead_q    <= lead_d;
    end
  end

  // One line store bank per window row; the newest row goes to bank slot_q.
  for (genvar b = 0; b < WINDOW_SIZE; b++) begin : g_bank
    logic [PIXEL_BITS-1:0] mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (accept && store && (slot_q == SW'(b))) begin
        mem[in_col_q] <= pix_v;
      end
      if (accept) begin
        rd_q <= mem[in_col_q];
      end
    end

    assign rd_w[b] = rd_q;
  end

  // Second step: the beat waits here while the column is read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_emit_q <= emit;
      s1_last_q <= last;
      s1_pix_q  <= pix_v;
      s1_slot_q <= slot_q;
      s1_ok_q   <= ok;
    end
  end

  // Assemble the new column and slide the window by one.
  always_comb begin
    for (int dy = 0; dy < WINDOW_SIZE; dy++) begin
      if (dy == WINDOW_SIZE - 1) begin
        col[dy] = s1_pix_q;
      end else begin
        col[dy] = rd_w[bank_of(s1_slot_q, dy)];
      end
      for (int dx = 0; dx < WINDOW_SIZE; dx++) begin
        if (dx == WINDOW_SIZE - 1) begin
          win_d[dy][dx] = col[dy];
        end else begin
          win_d[dy][dx] = win_q[dy][dx+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int dy = 0; dy < WINDOW_SIZE; dy++) begin
        for (int dx = 0; dx < WINDOW_SIZE; dx++) begin
          win_q[dy][dx] <= '0;
        end
      end
    end else if (s1_vld_q) begin
      win_q <= win_d;
    end
  end

  // Windows that produce an output go to the queue.
  assign push_o = s1_vld_q && s1_emit_q;

  always_comb begin
    entry_o = '0;
    for (int dy = 0; dy < WINDOW_SIZE; dy++) begin
      for (int dx = 0; dx < WINDOW_SIZE; dx++) begin
        entry_o[(dy*WINDOW_SIZE+dx)*PIXEL_BITS +: PIXEL_BITS] = win_d[dy][dx];
      end
    end
    entry_o[TAPS*PIXEL_BITS +: TAPS] = s1_ok_q;
    entry_o[TAPS*(PIXEL_BITS+1)]     = s1_last_q;
  end

endmodule

// ----- hdl/mmf_queue.sv -----
// Short queue of windows between the front and back parts.
module mmf_queue #(
  parameter int unsigned ENTRY_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [ENTRY_W-1:0] entry_i,
  input  logic               pop_i,
  output logic               vld_o,
  output logic [ENTRY_W-1:0] head_o,
  output mmf_pkg::qcnt_t     cnt_o
);
  import mmf_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  logic [ENTRY_W-1:0] slot_q [QUEUE_DEPTH];
  logic [PW-1:0]      wr_q, rd_q;
  qcnt_t              cnt_q;

  assign vld_o  = (cnt_q != '0);
  assign head_o = slot_q[rd_q];
  assign cnt_o  = cnt_q;

  // Storage; the front never pushes into a full queue.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + qcnt_t'(push_i) - qcnt_t'(pop_i);
    end
  end

endmodule

// ----- hdl/mmf_back.sv -----
// Back part: weights the window, sorts it through a pipelined network, picks the median.
module mmf_back #(
  parameter int unsigned WINDOW_SIZE = mmf_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned PIXEL_BITS  = mmf_pkg::PIXEL_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_vld_i,
  input  logic [WINDOW_SIZE*WINDOW_SIZE*(PIXEL_BITS+1):0] q_entry_i,
  input  logic [WINDOW_SIZE*WINDOW_SIZE*mmf_pkg::WEIGHT_W-1:0] weights_i,
  output logic pop_o,
  mmf_out_if.source out_m
);
  import mmf_pkg::*;

  localparam int unsigned TAPS = WINDOW_SIZE * WINDOW_SIZE;
  localparam int unsigned OW   = PIXEL_BITS + WEIGHT_W;
  localparam int unsigned NS   = TAPS + 1;
  localparam int unsigned NW   = $clog2(TAPS + 1);
  localparam int unsigned IW   = (TAPS > 1) ? $clog2(TAPS) : 1;

  // Zero products rank above every kept product.
  function automatic logic ranks_above(input logic signed [OW-1:0] a, input logic na,
                                       input logic signed [OW-1:0] b, input logic nb);
    return (!na && nb) || (na && nb && (a > b));
  endfunction

  logic signed [OW:0]   full [TAPS];
  logic signed [OW-1:0] prod [TAPS];
  logic [TAPS-1:0]      prod_nz;
  logic signed [OW-1:0] val_q [NS][TAPS];
  logic [TAPS-1:0]      nz_q [NS];
  logic [NS-1:0]        last_q, vld_q;
  logic signed [OW-1:0] nv [NS-1][TAPS];
  logic [TAPS-1:0]      nn [NS-1];
  logic [NS:0]          free;
  logic [NW-1:0]        cnt;
  logic [IW-1:0]        hi, lo;
  logic signed [OW:0]   sum;
  logic signed [OW-1:0] med;
  logic                 out_vld_q, out_empty_q, out_last_q;
  logic signed [OW-1:0] out_filt_q;

  // Weighted products; taps outside the frame count as zero.
  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      full[k] = $signed(q_entry_i[k*PIXEL_BITS +: PIXEL_BITS]) *
                $signed({1'b0, weights_i[k*WEIGHT_W +: WEIGHT_W]});
      prod[k] = q_entry_i[TAPS*PIXEL_BITS + k] ? full[k][OW-1:0] : '0;
      prod_nz[k] = (prod[k] != '0);
    end
  end

  // One odd-even transposition layer per stage.
  always_comb begin
    for (int s = 0; s < NS - 1; s++) begin
      nv[s] = val_q[s];
      nn[s] = nz_q[s];
      for (int i = s % 2; i + 1 < TAPS; i += 2) begin
        if (ranks_above(val_q[s][i], nz_q[s][i], val_q[s][i+1], nz_q[s][i+1])) begin
          nv[s][i]   = val_q[s][i+1];
          nv[s][i+1] = val_q[s][i];
          nn[s][i]   = nz_q[s][i+1];
          nn[s][i+1] = nz_q[s][i];
        end
      end
    end
  end

  // A stage takes new data when it is empty or its contents move on.
  always_comb begin
    free[NS] = !out_vld_q || out_m.ready;
    for (int s = NS - 1; s >= 0; s--) begin
      free[s] = !vld_q[s] || free[s+1];
    end
  end

  assign pop_o = q_vld_i && free[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (free[0]) vld_q[0] <= q_vld_i;
      for (int s = 1; s < NS; s++) begin
        if (free[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free[0]) begin
      val_q[0]  <= prod;
      nz_q[0]   <= prod_nz;
      last_q[0] <= q_entry_i[TAPS*(PIXEL_BITS+1)];
    end
    for (int s = 1; s < NS; s++) begin
      if (free[s]) begin
        val_q[s]  <= nv[s-1];
        nz_q[s]   <= nn[s-1];
        last_q[s] <= last_q[s-1];
      end
    end
  end

  // Median of the kept products; an even count takes the floor of the mean.
  always_comb begin
    cnt = NW'($countones(nz_q[NS-1]));
    hi  = IW'(cnt >> 1);
    lo  = hi - 1'b1;
    sum = {val_q[NS-1][lo][OW-1], val_q[NS-1][lo]} +
          {val_q[NS-1][hi][OW-1], val_q[NS-1][hi]};
    if (cnt == '0) begin
      med = '0;
    end else if (cnt[0]) begin
      med = val_q[NS-1][hi];
    end else begin
      med = sum[OW:1];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (free[NS]) begin
      out_vld_q <= vld_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (free[NS]) begin
      out_filt_q  <= med;
      out_empty_q <= (cnt == '0);
      out_last_q  <= last_q[NS-1];
    end
  end

  assign out_m.valid         = out_vld_q;
  assign out_m.filtered      = out_filt_q;
  assign out_m.window_empty  = out_empty_q;
  assign out_m.last_of_frame = out_last_q;

endmodule

// ----- hdl/masked_median_filter_2d_top.sv -----
// Top level of the masked median filter: configuration registers and the two parts.
//
//  Channel  Dir  Payload                                   Beat when
//  in_s     in   kind, pixel                               valid && ready
//  out_m    out  filtered, window_empty, last_of_frame     valid && ready
//  cfg      in   cfg_idx_i, cfg_data_i                     cfg_we_i
//
// One pixel beat per cycle is sustained while the output is not stalled; the front takes
// a beat whenever the queue has room for it, independent of the output. The beat that
// completes a window reaches its result through the window step into the queue, the
// product stage, one sorting layer per tap and the output register.
// Reset clears positions, window and pipeline; the line stores are not cleared.
// An output stall backs up the sort pipeline and then the queue before the input stalls.
module masked_median_filter_2d_top #(
  parameter int unsigned WINDOW_SIZE = mmf_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned MAX_WIDTH   = mmf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS  = mmf_pkg::PIXEL_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mmf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mmf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  mmf_in_if.sink                           in_s,
  mmf_out_if.source                        out_m
);
  import mmf_pkg::*;

  localparam int unsigned TAPS    = WINDOW_SIZE * WINDOW_SIZE;
  localparam int unsigned ENTRY_W = TAPS * (PIXEL_BITS + 1) + 1;

  logic [WIDTH_W-1:0]        width_q;
  logic [HEIGHT_W-1:0]       height_q;
  logic [CFG_DATA_W-1:0]     mask_lo_q, mask_hi_q;
  geom_t                     geom;
  logic [TAPS*WEIGHT_W-1:0]  weights;
  qcnt_t                     q_cnt;
  logic                      push, pop, q_vld;
  logic [ENTRY_W-1:0]        entry, head;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WIDTH_RST;
      height_q  <= HEIGHT_RST;
      mask_lo_q <= MASK_LO_RST;
      mask_hi_q <= MASK_HI_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:   width_q   <= cfg_data_i[WIDTH_W-1:0];
        CFG_HEIGHT:  height_q  <= cfg_data_i[HEIGHT_W-1:0];
        CFG_MASK_LO: mask_lo_q <= cfg_data_i;
        CFG_MASK_HI: mask_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective geometry: zero acts as one, width clamps to the line store size.
  always_comb begin
    if (width_q == '0) begin
      geom.width = WIDTH_W'(1);
    end else if ({2'b00, width_q} > (WIDTH_W+2)'(MAX_WIDTH)) begin
      geom.width = WIDTH_W'(MAX_WIDTH);
    end else begin
      geom.width = width_q;
    end
    geom.height  = (height_q == '0) ? HEIGHT_W'(1) : height_q;
    geom.restart = cfg_we_i && ((cfg_idx_e'(cfg_idx_i) == CFG_WIDTH) ||
                                (cfg_idx_e'(cfg_idx_i) == CFG_HEIGHT));
  end

  // Saturated weight per tap, in raster order over the two mask registers.
  for (genvar k = 0; k < TAPS; k++) begin : g_weight
    logic [WEIGHT_W-1:0] nib;
    if (k < 16) begin : g_lo
      assign nib = mask_lo_q[k*WEIGHT_W +: WEIGHT_W];
    end else begin : g_hi
      assign nib = mask_hi_q[(k-16)*WEIGHT_W +: WEIGHT_W];
    end
    assign weights[k*WEIGHT_W +: WEIGHT_W] = sat_weight(nib);
  end

  mmf_front #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .MAX_WIDTH   (MAX_WIDTH),
    .PIXEL_BITS  (PIXEL_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .geom_i  (geom),
    .q_cnt_i (q_cnt),
    .in_s    (in_s),
    .push_o  (push),
    .entry_o (entry)
  );

  mmf_queue #(
    .ENTRY_W (ENTRY_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .vld_o   (q_vld),
    .head_o  (head),
    .cnt_o   (q_cnt)
  );

  mmf_back #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .PIXEL_BITS  (PIXEL_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_vld_i   (q_vld),
    .q_entry_i (head),
    .weights_i (weights),
    .pop_o     (pop),
    .out_m     (out_m)
  );

endmodule

// ----- hdl/mmf_checker.sv -----
// Port-level checks on the masked median filter output, bound to the top level.
module mmf_checker #(
  parameter int unsigned OUT_W = mmf_pkg::PIXEL_BITS_DEF + mmf_pkg::WEIGHT_W
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [OUT_W-1:0] out_filtered_i,
  input logic                    out_empty_i,
  input logic                    out_last_i
);

  // A stalled output beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_filtered_i) &&
                                    $stable(out_empty_i) && $stable(out_last_i))
    else $error("output beat changed while stalled");

  // An empty window reports zero.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_empty_i |-> out_filtered_i == '0)
    else $error("empty window with nonzero median");

  // No output beat is offered while reset is held.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

endmodule

bind masked_median_filter_2d_top mmf_checker #(
  .OUT_W (PIXEL_BITS + mmf_pkg::WEIGHT_W)
) u_mmf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_m.valid),
  .out_ready_i    (out_m.ready),
  .out_filtered_i (out_m.filtered),
  .out_empty_i    (out_m.window_empty),
  .out_last_i     (out_m.last_of_frame)
);

// ----- test/masked_median_filter_2d_checker.sv -----
// Checker for the masked median filter: predicts every filtered beat and compares it.
`timescale 1ns / 1ps

module masked_median_filter_2d_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mmf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mmf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mmf_in_if                              in_w,
  mmf_out_if                             out_w,
  output int                             mismatch_count,
  output int                             pending_count
);
  import mmf_pkg::*;

  localparam int WIN      = 3;
  localparam int HALF     = WIN / 2;
  localparam int ROWS     = 2 * WIN;
  localparam int MAXW     = 1024;

  typedef struct packed {
    logic signed [27:0] filtered;
    logic               window_empty;
    logic               last_of_frame;
  } filt_beat_t;

  filt_beat_t expected_q[$];
  int         pixel_rows[ROWS][MAXW];
  int         in_col, in_row, out_col, out_row;
  logic [WIDTH_W-1:0]    width_reg;
  logic [HEIGHT_W-1:0]   height_reg;
  logic [CFG_DATA_W-1:0] mask_lo_reg, mask_hi_reg;

  // Mask weight of one tap, saturated at the largest legal weight.
  function automatic int tap_weight(int k);
    logic [3:0] w;
    if (k < 16) w = mask_lo_reg[4*k +: 4];
    else w = mask_hi_reg[4*(k-16) +: 4];
    return (w > 4'd9) ? 9 : int'(w);
  endfunction

  // Advance the filter by one pixel beat and queue the result it causes.
  task automatic filter_pixel(input logic kind, input logic signed [23:0] px);
    int w, h, total, t, lat, n, med, r, c, pv, prod, j, s;
    int vals[9];
    filt_beat_t res;
    w = (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : int'(width_reg));
    h = (height_reg == 0) ? 1 : int'(height_reg);
    total = w * h;
    t = in_row * w + in_col;
    lat = HALF * w + HALF;
    if (t < total) pixel_rows[in_row % ROWS][in_col] = (kind == 1'b0) ? int'(px) : 0;
    if (t >= lat) begin
      n = 0;
      for (int dy = 0; dy < WIN; dy++) begin
        for (int dx = 0; dx < WIN; dx++) begin
          r = out_row - HALF + dy;
          c = out_col - HALF + dx;
          pv = 0;
          if (r >= 0 && r < h && c >= 0 && c < w) pv = pixel_rows[r % ROWS][c];
          prod = pv * tap_weight(dy * WIN + dx);
          if (prod != 0) begin
            // Insertion sort keeps the nonzero products in ascending order.
            j = n;
            while (j > 0 && vals[j-1] > prod) begin
              vals[j] = vals[j-1];
              j--;
            end
            vals[j] = prod;
            n++;
          end
        end
      end
      med = 0;
      if (n > 0) begin
        if (n % 2 == 1) begin
          med = vals[n/2];
        end else begin
          // Mean of the middle pair, rounded toward minus infinity.
          s = vals[n/2-1] + vals[n/2];
          med = s >>> 1;
        end
      end
      res.filtered = med[27:0];
      res.window_empty = (n == 0);
      res.last_of_frame = (out_row * w + out_col + 1 >= total);
      expected_q.insert(expected_q.size(), res);
      if (res.last_of_frame) begin
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        return;
      end
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
  endtask

  // Watch configuration writes and both channels.
  always @(posedge clk_i or negedge rst_ni) begin
    filt_beat_t got, exp_beat;
    if (!rst_ni) begin
      expected_q.delete();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      width_reg = WIDTH_RST;
      height_reg = HEIGHT_RST;
      mask_lo_reg = MASK_LO_RST;
      mask_hi_reg = MASK_HI_RST;
      mismatch_count = 0;
      pending_count = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_WIDTH: begin
            width_reg = cfg_data_i[WIDTH_W-1:0];
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
          end
          CFG_HEIGHT: begin
            height_reg = cfg_data_i[HEIGHT_W-1:0];
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
          end
          CFG_MASK_LO: mask_lo_reg = cfg_data_i;
          CFG_MASK_HI: mask_hi_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (out_w.valid && out_w.ready) begin
        got.filtered = out_w.filtered;
        got.window_empty = out_w.window_empty;
        got.last_of_frame = out_w.last_of_frame;
        if (expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected filtered beat: filtered=%0d empty=%0b last=%0b",
                     got.filtered, got.window_empty, got.last_of_frame);
        end else begin
          exp_beat = expected_q.pop_front();
          if (got !== exp_beat) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch: expected filtered=%0d empty=%0b last=%0b, got %0d %0b %0b",
                       exp_beat.filtered, exp_beat.window_empty, exp_beat.last_of_frame,
                       got.filtered, got.window_empty, got.last_of_frame);
          end
        end
      end
      if (in_w.valid && in_w.ready) filter_pixel(in_w.kind, in_w.pixel);
      pending_count = expected_q.size();
    end
  end

endmodule

// ----- test/masked_median_filter_2d_top_tb.sv -----
// Testbench top for the masked median filter: stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module masked_median_filter_2d_top_tb;
  import mmf_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    mismatch_count;
  int                    pending_count;
  int                    pixels_sent;
  bit                    steady_mode;

  mmf_in_if  in_if ();
  mmf_out_if out_if ();

  masked_median_filter_2d_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_s       (in_if),
    .out_m      (out_if)
  );

  masked_median_filter_2d_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_w           (in_if),
    .out_w          (out_if),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // Clock.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Run limit.
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Output side: a random stall before each filtered beat.
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady_mode ? 0 : $urandom_range(0, 17);
      @(posedge clk_i);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      forever begin
        @(negedge clk_i);
        if (out_if.valid) break;
      end
    end
  end

  // One pixel beat with a random gap in front of it.
  task automatic send_beat(input logic kind, input logic signed [23:0] px);
    int gap;
    gap = steady_mode ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.pixel <= px;
    forever begin
      @(negedge clk_i);
      if (in_if.ready) break;
    end
    @(posedge clk_i);
    pixels_sent++;
  endtask

  // Wait until the block is idle, then write all four registers.
  task automatic configure(input logic [10:0] w, input logic [11:0] h,
                           input logic [63:0] lo, input logic [63:0] hi);
    in_if.valid <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (pending_count == 0) break;
    end
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_WIDTH;
    cfg_data_i <= {53'd0, w};
    @(posedge clk_i);
    cfg_idx_i <= CFG_HEIGHT;
    cfg_data_i <= {52'd0, h};
    @(posedge clk_i);
    cfg_idx_i <= CFG_MASK_LO;
    cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_idx_i <= CFG_MASK_HI;
    cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [23:0] random_pixel();
    case ($urandom_range(0, 7))
      0, 1: return 24'sd0;
      2: return $urandom_range(0, 1) ? 24'sh800000 : 24'sh7fffff;
      3: return 24'($signed($urandom_range(0, 510)) - 255);
      default: return 24'($urandom);
    endcase
  endfunction

  // A frame of random pixels and its flush tail; cut < 0 sends it whole.
  task automatic send_frame(input logic [10:0] w_reg, input logic [11:0] h_reg,
                            input int cut);
    int w, h, total, beats;
    w = (w_reg == 0) ? 1 : ((w_reg > 1024) ? 1024 : int'(w_reg));
    h = (h_reg == 0) ? 1 : int'(h_reg);
    total = w * h;
    beats = total + w + 1;
    if (cut >= 0 && cut < beats) beats = cut;
    for (int i = 0; i < beats; i++) begin
      if (i < total) send_beat(($urandom_range(0, 39) == 0), random_pixel());
      else if ($urandom_range(0, 5) == 0) send_beat(1'b0, random_pixel());
      else send_beat(1'b1, 24'($urandom));
    end
  endtask

  // Stimulus and verdict.
  initial begin
    logic signed [23:0] corner_px[9];
    logic [10:0] w;
    logic [11:0] h;
    logic [63:0] lo, hi;
    rst_ni = 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_WIDTH;
    cfg_data_i <= '0;
    in_if.valid <= 1'b0;
    in_if.kind <= 1'b0;
    in_if.pixel <= '0;
    pixels_sent = 0;
    steady_mode = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-pixel frame with every weight saturating.
    configure(11'd1, 12'd1, '1, '1);
    send_beat(1'b0, 24'sh800000);
    send_beat(1'b1, 24'sh7fffff);
    send_beat(1'b0, 24'sh123456);

    // Zero geometry acts as one pixel.
    configure(11'd0, 12'd0, 64'h0000_0009_8765_4321, '0);
    send_beat(1'b0, 24'sh7fffff);
    send_beat(1'b1, 24'sd0);
    send_beat(1'b1, 24'sd0);

    // 3x3 frame: extremes, a flush inside the frame, an even count with a negative sum.
    corner_px = '{24'sh800000, 24'sh7fffff, 24'sd0, -24'sd3, 24'sd0,
                  24'sh800000, 24'sd1, 24'sd0, 24'sh7fffff};
    steady_mode = 1'b1;
    configure(11'd3, 12'd3, 64'h0000_000f_a876_5321, 64'hffff_ffff_ffff_ffff);
    for (int i = 0; i < 9; i++) send_beat((i == 4), corner_px[i]);
    for (int i = 0; i < 4; i++) send_beat(1'b0, 24'sh7fffff);
    steady_mode = 1'b0;

    // Zero mask: every window empty.
    configure(11'd2, 12'd2, '0, '0);
    for (int i = 0; i < 7; i++) send_beat(1'b0, random_pixel());

    // Widest row and tallest frame, each cut short once outputs have started.
    configure(11'd2047, 12'd1, {$urandom, $urandom}, {$urandom, $urandom});
    send_frame(11'd2047, 12'd1, 1040);
    configure(11'd1, 12'd4095, 64'h0000_0001_1111_1111, '0);
    send_frame(11'd1, 12'd4095, 120);

    // Random frames, some abandoned partway through.
    while (pixels_sent < 1650) begin
      w = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 40)) : 11'($urandom_range(1, 9));
      h = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 8));
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      if ($urandom_range(0, 2) == 0) lo = lo & {$urandom, $urandom};
      steady_mode = ($urandom_range(0, 4) == 0);
      configure(w, h, lo, hi);
      repeat ($urandom_range(1, 3)) begin
        send_frame(w, h, ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 30)) : -1);
      end
    end
    steady_mode = 1'b0;
    in_if.valid <= 1'b0;

    forever begin
      @(negedge clk_i);
      if (pending_count == 0) break;
    end
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
